// File: rtl/mmh_pkg.sv
// Shared types, codes and helpers of the min-max heap priority queue.
package mmh_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 11;

    // Operation codes on the opcode port.
    localparam logic [1:0] OPC_INSERT  = 2'd0;
    localparam logic [1:0] OPC_DEL_MIN = 2'd1;
    localparam logic [1:0] OPC_DEL_MAX = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef logic signed [KEY_W-1:0] key_t;

    // One datapath micro-operation per cycle.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_INS_PLACE,
        OP_INS_PAR,
        OP_RD_GRAND,
        OP_BUB_MOVE,
        OP_PUT,
        OP_SEL_MIN,
        OP_RD2,
        OP_RD3,
        OP_SEL_MAX,
        OP_DEL_RDI,
        OP_DEL_RDL,
        OP_DEL_TAKE,
        OP_SCAN_START,
        OP_SCAN,
        OP_TR_DEC,
        OP_TR_PAR,
        OP_VIEW_RD1,
        OP_VIEW_RD2,
        OP_VIEW_SET
    } dp_op_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic i_one;
        logic has_grand;
        logic bub_beats;
        logic tr_stop;
        logic scan_end;
        logic tr_move;
        logic tr_grand;
    } dp_stat_t;

    // True when x belongs above y on a level of the given kind.
    function automatic logic beats(input key_t x, input key_t y, input logic is_min);
        return is_min ? (x < y) : (x > y);
    endfunction

endpackage

// File: rtl/mmh_datapath.sv
// Heap memory, position and key registers of the min-max heap.
module mmh_datapath #(
    parameter int CAPACITY = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mmh_pkg::dp_op_t   op,
    input  mmh_pkg::key_t     key_in,
    output mmh_pkg::dp_stat_t stat,
    output mmh_pkg::key_t     removed_key,
    output mmh_pkg::key_t     current_min,
    output mmh_pkg::key_t     current_max,
    output logic [mmh_pkg::COUNT_W-1:0] entry_count,
    output logic              is_empty
);

    localparam int AW = $clog2(CAPACITY + 1);
    localparam int WW = AW + 2;

    mmh_pkg::key_t mem [0:CAPACITY];

    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] m_reg, m_next;
    logic [AW-1:0] pc_reg, pc_next;
    logic [2:0]    k_reg, k_next;
    logic          pend_reg, pend_next;
    logic          bestv_reg, bestv_next;
    logic          ismin_reg, ismin_next;
    mmh_pkg::key_t vi_reg, vi_next;
    mmh_pkg::key_t vm_reg, vm_next;
    mmh_pkg::key_t v2_reg, v2_next;
    mmh_pkg::key_t rem_reg, rem_next;
    mmh_pkg::key_t min_reg, min_next;
    mmh_pkg::key_t max_reg, max_next;
    mmh_pkg::key_t rd_reg;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    mmh_pkg::key_t wdata;

    logic [AW-1:0] cnt_inc;
    logic [WW-1:0] cnt_w, i2_w, i4_w, m_w, cand_w;
    logic          cand_ok;

    // Level parity: true when the highest set bit sits at an even place.
    function automatic logic level_min(input logic [AW-1:0] pos);
        logic r;
        r = 1'b1;
        for (int b = 0; b < AW; b++) begin
            if (pos[b]) begin
                r = ((b % 2) == 0);
            end
        end
        return r;
    endfunction

    assign cnt_inc = cnt_reg + AW'(1);
    assign cnt_w   = WW'(cnt_reg);
    assign i2_w    = {1'b0, i_reg, 1'b0};
    assign i4_w    = {i_reg, 2'b00};
    assign m_w     = WW'(m_reg);

    always_comb
    begin
        case (k_reg)
            3'd0:    cand_w = i2_w;
            3'd1:    cand_w = i2_w + WW'(1);
            3'd2:    cand_w = i4_w;
            3'd3:    cand_w = i4_w + WW'(1);
            3'd4:    cand_w = i4_w + WW'(2);
            default: cand_w = i4_w + WW'(3);
        endcase
    end
    assign cand_ok = (k_reg < 3'd6) && (cand_w <= cnt_w);

    assign stat.full      = (cnt_reg == AW'(CAPACITY));
    assign stat.empty     = (cnt_reg == '0);
    assign stat.i_one     = (i_reg == AW'(1));
    assign stat.has_grand = (i_reg >= AW'(4));
    assign stat.bub_beats = mmh_pkg::beats(vi_reg, rd_reg, ismin_reg);
    assign stat.tr_stop   = (i2_w > cnt_w);
    assign stat.scan_end  = (k_reg == 3'd6);
    assign stat.tr_move   = mmh_pkg::beats(vm_reg, vi_reg, ismin_reg);
    assign stat.tr_grand  = (m_w >= i4_w);

    always_comb
    begin
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        m_next     = m_reg;
        pc_next    = pc_reg;
        k_next     = k_reg;
        pend_next  = pend_reg;
        bestv_next = bestv_reg;
        ismin_next = ismin_reg;
        vi_next    = vi_reg;
        vm_next    = vm_reg;
        v2_next    = v2_reg;
        rem_next   = rem_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        we    = 1'b0;
        waddr = i_reg;
        wdata = vi_reg;
        re    = 1'b0;
        raddr = i_reg;
        unique case (op)
            mmh_pkg::OP_LATCH:
            begin
                vi_next  = key_in;
                rem_next = '0;
            end
            mmh_pkg::OP_INS_PLACE:
            begin
                cnt_next   = cnt_inc;
                i_next     = cnt_inc;
                ismin_next = level_min(cnt_inc);
                we    = 1'b1;
                waddr = cnt_inc;
                re    = 1'b1;
                raddr = cnt_inc >> 1;
            end
            mmh_pkg::OP_INS_PAR:
            begin
                // The new key belongs on the other kind of level: park the parent below.
                if (mmh_pkg::beats(rd_reg, vi_reg, ismin_reg)) begin
                    we         = 1'b1;
                    wdata      = rd_reg;
                    i_next     = i_reg >> 1;
                    ismin_next = !ismin_reg;
                end
            end
            mmh_pkg::OP_RD_GRAND:
            begin
                re    = 1'b1;
                raddr = i_reg >> 2;
            end
            mmh_pkg::OP_BUB_MOVE:
            begin
                we     = 1'b1;
                wdata  = rd_reg;
                i_next = i_reg >> 2;
            end
            mmh_pkg::OP_PUT:
            begin
                we = 1'b1;
            end
            mmh_pkg::OP_SEL_MIN:
            begin
                i_next = AW'(1);
            end
            mmh_pkg::OP_RD2:
            begin
                re    = 1'b1;
                raddr = AW'(2);
            end
            mmh_pkg::OP_RD3:
            begin
                v2_next = rd_reg;
                re      = 1'b1;
                raddr   = AW'(3);
            end
            mmh_pkg::OP_SEL_MAX:
            begin
                if (cnt_reg == AW'(1)) begin
                    i_next = AW'(1);
                end else if (cnt_reg == AW'(2) || v2_reg > rd_reg) begin
                    i_next = AW'(2);
                end else begin
                    i_next = AW'(3);
                end
            end
            mmh_pkg::OP_DEL_RDI:
            begin
                re = 1'b1;
            end
            mmh_pkg::OP_DEL_RDL:
            begin
                rem_next = rd_reg;
                re       = 1'b1;
                raddr    = cnt_reg;
            end
            mmh_pkg::OP_DEL_TAKE:
            begin
                vi_next    = rd_reg;
                cnt_next   = cnt_reg - AW'(1);
                ismin_next = level_min(i_reg);
            end
            mmh_pkg::OP_SCAN_START:
            begin
                k_next     = '0;
                pend_next  = 1'b0;
                bestv_next = 1'b0;
            end
            mmh_pkg::OP_SCAN:
            begin
                // Compare the candidate read last cycle while reading the next one.
                if (pend_reg && (!bestv_reg || mmh_pkg::beats(rd_reg, vm_reg, ismin_reg))) begin
                    m_next     = pc_reg;
                    vm_next    = rd_reg;
                    bestv_next = 1'b1;
                end
                pend_next = cand_ok;
                pc_next   = cand_w[AW-1:0];
                re        = cand_ok;
                raddr     = cand_w[AW-1:0];
                if (k_reg < 3'd6) begin
                    k_next = k_reg + 3'd1;
                end
            end
            mmh_pkg::OP_TR_DEC:
            begin
                if (mmh_pkg::beats(vm_reg, vi_reg, ismin_reg)) begin
                    we     = 1'b1;
                    wdata  = vm_reg;
                    i_next = m_reg;
                    re     = 1'b1;
                    raddr  = m_reg >> 1;
                end
            end
            mmh_pkg::OP_TR_PAR:
            begin
                if (mmh_pkg::beats(rd_reg, vi_reg, ismin_reg)) begin
                    we      = 1'b1;
                    waddr   = i_reg >> 1;
                    vi_next = rd_reg;
                end
            end
            mmh_pkg::OP_VIEW_RD1:
            begin
                re    = 1'b1;
                raddr = AW'(1);
            end
            mmh_pkg::OP_VIEW_RD2:
            begin
                min_next = rd_reg;
                re       = 1'b1;
                raddr    = AW'(2);
            end
            mmh_pkg::OP_VIEW_SET:
            begin
                if (cnt_reg == '0) begin
                    min_next = '0;
                    max_next = '0;
                end else if (cnt_reg == AW'(1)) begin
                    max_next = min_reg;
                end else if (cnt_reg == AW'(2) || v2_reg > rd_reg) begin
                    max_next = v2_reg;
                end else begin
                    max_next = rd_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg   <= '0;
            k_reg     <= '0;
            pend_reg  <= 1'b0;
            bestv_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            pend_reg  <= pend_next;
            bestv_reg <= bestv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        m_reg     <= m_next;
        pc_reg    <= pc_next;
        ismin_reg <= ismin_next;
        vi_reg    <= vi_next;
        vm_reg    <= vm_next;
        v2_reg    <= v2_next;
        rem_reg   <= rem_next;
        min_reg   <= min_next;
        max_reg   <= max_next;
    end

    assign removed_key = rem_reg;
    assign current_min = min_reg;
    assign current_max = max_reg;
    assign entry_count = mmh_pkg::COUNT_W'(cnt_reg);
    assign is_empty    = (cnt_reg == '0);

endmodule

// File: rtl/mmh_controller.sv
// Sequencing state machine of the min-max heap priority queue.
module mmh_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        opcode,
    input  mmh_pkg::dp_stat_t stat,
    output mmh_pkg::dp_op_t   op,
    output logic              busy,
    output logic              done,
    output logic [1:0]        status,
    output logic              removed_valid
);

    typedef enum logic [20:0] {
        S_IDLE     = 21'h000001,
        S_INS      = 21'h000002,
        S_INS_PAR  = 21'h000004,
        S_BUB_RD   = 21'h000008,
        S_BUB_CMP  = 21'h000010,
        S_SEL_MIN  = 21'h000020,
        S_MAX_RD2  = 21'h000040,
        S_MAX_RD3  = 21'h000080,
        S_MAX_SEL  = 21'h000100,
        S_DEL_RDI  = 21'h000200,
        S_DEL_RDL  = 21'h000400,
        S_DEL_TAKE = 21'h000800,
        S_TR_CHK   = 21'h001000,
        S_SCAN     = 21'h002000,
        S_TR_DEC   = 21'h004000,
        S_TR_PAR   = 21'h008000,
        S_PUT      = 21'h010000,
        S_V1       = 21'h020000,
        S_V2       = 21'h040000,
        S_V3       = 21'h080000,
        S_DONE     = 21'h100000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       rvalid_reg, rvalid_next;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        rvalid_next = rvalid_reg;
        op          = mmh_pkg::OP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start) begin
                    op          = mmh_pkg::OP_LATCH;
                    status_next = mmh_pkg::STAT_OK;
                    rvalid_next = 1'b0;
                    unique case (opcode) inside
                        mmh_pkg::OPC_INSERT:
                        begin
                            if (stat.full) begin
                                status_next = mmh_pkg::STAT_FULL;
                                state_next  = S_V1;
                            end else begin
                                state_next = S_INS;
                            end
                        end
                        mmh_pkg::OPC_DEL_MIN, mmh_pkg::OPC_DEL_MAX:
                        begin
                            if (stat.empty) begin
                                status_next = mmh_pkg::STAT_EMPTY;
                                state_next  = S_V1;
                            end else begin
                                rvalid_next = 1'b1;
                                state_next  = (opcode == mmh_pkg::OPC_DEL_MIN) ?
                                              S_SEL_MIN : S_MAX_RD2;
                            end
                        end
                        default:
                        begin
                            state_next = S_V1;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                op         = mmh_pkg::OP_INS_PLACE;
                state_next = S_INS_PAR;
            end
            S_INS_PAR:
            begin
                if (stat.i_one) begin
                    state_next = S_V1;
                end else begin
                    op         = mmh_pkg::OP_INS_PAR;
                    state_next = S_BUB_RD;
                end
            end
            S_BUB_RD:
            begin
                if (stat.has_grand) begin
                    op         = mmh_pkg::OP_RD_GRAND;
                    state_next = S_BUB_CMP;
                end else begin
                    op         = mmh_pkg::OP_PUT;
                    state_next = S_V1;
                end
            end
            S_BUB_CMP:
            begin
                if (stat.bub_beats) begin
                    op         = mmh_pkg::OP_BUB_MOVE;
                    state_next = S_BUB_RD;
                end else begin
                    op         = mmh_pkg::OP_PUT;
                    state_next = S_V1;
                end
            end
            S_SEL_MIN:
            begin
                op         = mmh_pkg::OP_SEL_MIN;
                state_next = S_DEL_RDI;
            end
            S_MAX_RD2:
            begin
                op         = mmh_pkg::OP_RD2;
                state_next = S_MAX_RD3;
            end
            S_MAX_RD3:
            begin
                op         = mmh_pkg::OP_RD3;
                state_next = S_MAX_SEL;
            end
            S_MAX_SEL:
            begin
                op         = mmh_pkg::OP_SEL_MAX;
                state_next = S_DEL_RDI;
            end
            S_DEL_RDI:
            begin
                op         = mmh_pkg::OP_DEL_RDI;
                state_next = S_DEL_RDL;
            end
            S_DEL_RDL:
            begin
                op         = mmh_pkg::OP_DEL_RDL;
                state_next = S_DEL_TAKE;
            end
            S_DEL_TAKE:
            begin
                op         = mmh_pkg::OP_DEL_TAKE;
                state_next = S_TR_CHK;
            end
            S_TR_CHK:
            begin
                if (stat.tr_stop) begin
                    op         = mmh_pkg::OP_PUT;
                    state_next = S_V1;
                end else begin
                    op         = mmh_pkg::OP_SCAN_START;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                op = mmh_pkg::OP_SCAN;
                if (stat.scan_end) begin
                    state_next = S_TR_DEC;
                end
            end
            S_TR_DEC:
            begin
                op         = mmh_pkg::OP_TR_DEC;
                state_next = (stat.tr_move && stat.tr_grand) ? S_TR_PAR : S_PUT;
            end
            S_TR_PAR:
            begin
                op         = mmh_pkg::OP_TR_PAR;
                state_next = S_TR_CHK;
            end
            S_PUT:
            begin
                op         = mmh_pkg::OP_PUT;
                state_next = S_V1;
            end
            S_V1:
            begin
                op         = mmh_pkg::OP_VIEW_RD1;
                state_next = S_V2;
            end
            S_V2:
            begin
                op         = mmh_pkg::OP_VIEW_RD2;
                state_next = S_V3;
            end
            S_V3:
            begin
                op         = mmh_pkg::OP_RD3;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Settles the maximum before the result is shown for its one cycle on done.
                op         = mmh_pkg::OP_VIEW_SET;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            status_reg <= mmh_pkg::STAT_OK;
            rvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            rvalid_reg <= rvalid_next;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = 1'b0;
    assign status        = status_reg;
    assign removed_valid = rvalid_reg;

endmodule

// File: rtl/min_max_heap_priority_queue.sv
// Top level of the min-max heap priority queue: controller plus datapath.
// A rejected or unused operation only refreshes the view. An insert places the key,
// checks its parent and bubbles up one grandparent level per round; a delete takes the
// root or the larger of its children, moves the last entry there and trickles it down
// one grandchild level per round. One operation is in flight at a time; the next may
// start while done shows the result. The receiver cannot stall; reset empties the heap.
module min_max_heap_priority_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  opcode,
    input  logic signed [31:0]          key_in,
    output logic                        done,
    output logic signed [31:0]          removed_key,
    output logic                        removed_valid,
    output logic [1:0]                  status,
    output logic signed [31:0]          current_min,
    output logic signed [31:0]          current_max,
    output logic [mmh_pkg::COUNT_W-1:0] entry_count,
    output logic                        is_empty
);

    mmh_pkg::dp_op_t   op;
    mmh_pkg::dp_stat_t stat;
    logic              ctl_done;
    mmh_pkg::key_t     view_max;

    mmh_controller u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .opcode        (opcode),
        .stat          (stat),
        .op            (op),
        .busy          (busy),
        .done          (ctl_done),
        .status        (status),
        .removed_valid (removed_valid)
    );

    mmh_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .key_in      (key_in),
        .stat        (stat),
        .removed_key (removed_key),
        .current_min (current_min),
        .current_max (view_max),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

    // The strobe follows the view update so that every field is settled.
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= (op == mmh_pkg::OP_VIEW_SET) | ctl_done;
        end
    end

    assign done        = done_reg;
    assign current_max = view_max;

endmodule
